/* hdl/hurip_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the request-URI parser.
// No dependencies; imported by every module of the block.

package hurip_pkg;

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_STAR   = 11'b000_0000_0010,
        PH_SCHEME = 11'b000_0000_0100,
        PH_SLASH  = 11'b000_0000_1000,
        PH_HOST   = 11'b000_0001_0000,
        PH_PORT   = 11'b000_0010_0000,
        PH_PATH   = 11'b000_0100_0000,
        PH_QUERY  = 11'b000_1000_0000,
        PH_FRAG   = 11'b001_0000_0000,
        PH_OTHER  = 11'b010_0000_0000,
        PH_FINAL  = 11'b100_0000_0000
    } t_phase;

    localparam logic [3:0] ST_MORE     = 4'd0;
    localparam logic [3:0] ST_DONE     = 4'd1;
    localparam logic [3:0] ST_INVALID  = 4'd2;
    localparam logic [3:0] ST_BAD_STAR = 4'd3;
    localparam logic [3:0] ST_PATH     = 4'd4;
    localparam logic [3:0] ST_QUERY    = 4'd5;
    localparam logic [3:0] ST_FRAG     = 4'd6;
    localparam logic [3:0] ST_SCHEME   = 4'd7;
    localparam logic [3:0] ST_HOST     = 4'd8;
    localparam logic [3:0] ST_PORT     = 4'd9;
    localparam logic [3:0] ST_OVERFLOW = 4'd10;

    localparam logic [2:0] PT_NONE   = 3'd0;
    localparam logic [2:0] PT_SCHEME = 3'd1;
    localparam logic [2:0] PT_HOST   = 3'd2;
    localparam logic [2:0] PT_PATH   = 3'd3;
    localparam logic [2:0] PT_QUERY  = 3'd4;
    localparam logic [2:0] PT_FRAG   = 3'd5;
    localparam logic [2:0] PT_OTHER  = 3'd6;

    localparam logic [2:0] TY_UNKNOWN  = 3'd0;
    localparam logic [2:0] TY_ASTERISK = 3'd1;
    localparam logic [2:0] TY_HTTP     = 3'd2;
    localparam logic [2:0] TY_HTTPS    = 3'd3;
    localparam logic [2:0] TY_OTHER    = 3'd4;

    localparam logic [15:0] PART_LIMIT_RESET = 16'd4096;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  part;
        logic [7:0]  byte_out;
        logic        byte_kept;
        logic        part_end;
        logic [2:0]  uri_type;
        logic [15:0] port_value;
        logic        port_present;
        logic        default_path;
    } t_result;

endpackage

/* hdl/http_request_uri_parser.sv */
`timescale 1ns / 1ps
// Top level of the request-URI parser: config register, input stage, core, result stage.
// Depends on hurip_pkg, hurip_in_stage, hurip_core, hurip_out_stage.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | sink      | i_in_valid / o_in_ready    | i_in_byte, i_restart
//   out     | source    | o_out_valid / i_out_ready  | o_status .. o_default_path
//   cfg     | sink      | i_cfg_we                   | i_cfg_wdata (part limit)
//
// One transaction per cycle sustained while the out channel does not stall; each byte passes
// from input to result through the input register, then the step logic into the result register.
// Reset clears the parser to idle and sets the part limit to 4096.
// A stall on the out channel holds the result register, then the input register,
// and drops o_in_ready only when both are full.

module http_request_uri_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [2:0]  o_part,
    output logic [7:0]  o_byte_out,
    output logic        o_byte_kept,
    output logic        o_part_end,
    output logic [2:0]  o_uri_type,
    output logic [15:0] o_port_value,
    output logic        o_port_present,
    output logic        o_default_path,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import hurip_pkg::*;

    logic [15:0] r_part_limit;
    t_in         in_item;
    t_in         stage_item;
    logic        stage_valid;
    logic        out_free;
    logic        advance;
    t_result     step_result;
    t_result     out_result;

    assign in_item.in_byte = i_in_byte;
    assign in_item.restart = i_restart;
    assign advance         = stage_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_limit <= PART_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_part_limit <= i_cfg_wdata;
        end
    end

    hurip_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (advance),
        .o_item  (stage_item)
    );

    hurip_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (stage_item),
        .i_part_limit (r_part_limit),
        .o_result     (step_result)
    );

    hurip_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_status       = out_result.status;
    assign o_part         = out_result.part;
    assign o_byte_out     = out_result.byte_out;
    assign o_byte_kept    = out_result.byte_kept;
    assign o_part_end     = out_result.part_end;
    assign o_uri_type     = out_result.uri_type;
    assign o_port_value   = out_result.port_value;
    assign o_port_present = out_result.port_present;
    assign o_default_path = out_result.default_path;

    a_kept_means_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kept |-> o_status == ST_MORE)
        else $error("kept byte with terminal status");

    a_dropped_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_kept |-> o_byte_out == 8'd0)
        else $error("byte_out set on a dropped byte");

    a_port_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_port_present |-> o_port_value == 16'd0)
        else $error("port value without port digit");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

/* hdl/hurip_in_stage.sv */
`timescale 1ns / 1ps
// Input register stage: holds one accepted transaction until the core takes it.
// Depends on hurip_pkg.

module hurip_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hurip_pkg::t_in   i_item,
    output logic             o_valid,
    input  logic             i_take,
    output hurip_pkg::t_in   o_item
);
    import hurip_pkg::*;

    logic r_valid;
    t_in  r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/hurip_core.sv */
`timescale 1ns / 1ps
// Parser state and per-byte step logic: classifies one byte and updates state.
// Depends on hurip_pkg.

module hurip_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  hurip_pkg::t_in     i_item,
    input  logic [15:0]        i_part_limit,
    output hurip_pkg::t_result o_result
);
    import hurip_pkg::*;

    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_QUEST = 8'h3F;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [2:0] MATCH_NONE = 3'd7;
    localparam logic [19:0] PORT_CEILING = 20'd65536;

    function automatic logic f_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic f_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic f_alnum(input logic [7:0] c);
        return f_alpha(c) || f_digit(c);
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        return c == C_SPACE || c == C_TAB;
    endfunction

    function automatic logic f_pchar(input logic [7:0] c);
        return f_alnum(c) || c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h21 ||
               c == 8'h7E || c == 8'h2A || c == 8'h27 || c == 8'h28 || c == 8'h29 ||
               c == 8'h25 || c == 8'h3A || c == 8'h40 || c == 8'h26 || c == 8'h3D ||
               c == 8'h2B || c == 8'h24 || c == 8'h2C;
    endfunction

    function automatic logic f_uric(input logic [7:0] c);
        return f_pchar(c) || c == C_SEMI || c == C_SLASH || c == C_QUEST;
    endfunction

    function automatic logic [7:0] f_https_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h68;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h70;
            default: ch = 8'h73;
        endcase
        return ch;
    endfunction

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [2:0]  r_match, n_match;
    logic [15:0] r_port, n_port;
    logic        r_port_seen, n_port_seen;
    logic [2:0]  r_type, n_type;
    logic        r_implied, n_implied;

    t_phase      ph;
    logic [15:0] len;
    logic [2:0]  match;
    logic [7:0]  c;
    logic [7:0]  c_low;
    logic [2:0]  match_step;
    logic [15:0] n_port_base;
    logic [19:0] port_sum;
    logic        host_first;
    logic        want;
    logic [3:0]  st;
    logic [2:0]  pt;
    logic        kept;
    logic        pend;

    assign c     = i_item.in_byte;
    assign ph    = i_item.restart ? PH_IDLE : r_phase;
    assign len   = i_item.restart ? 16'd0 : r_len;
    assign match = i_item.restart ? 3'd0 : r_match;
    assign c_low = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    assign match_step = (len == {13'd0, match} && match < 3'd5 &&
                         c_low == f_https_char(match)) ? match + 3'd1 : MATCH_NONE;
    assign port_sum = {1'b0, n_port_base, 3'b000} + {3'b000, n_port_base, 1'b0} +
                      {16'd0, c[3:0] - 4'd0};

    assign n_port_base = i_item.restart ? 16'd0 : r_port;

    always_comb begin
        n_phase     = ph;
        n_len       = len;
        n_match     = match;
        n_port      = n_port_base;
        n_port_seen = i_item.restart ? 1'b0 : r_port_seen;
        n_type      = i_item.restart ? TY_UNKNOWN : r_type;
        n_implied   = i_item.restart ? 1'b0 : r_implied;
        st          = ST_MORE;
        pt          = PT_NONE;
        want        = 1'b0;
        pend        = 1'b0;
        host_first  = 1'b0;

        unique case (ph)
            PH_IDLE: begin
                if (f_space(c)) begin
                end else if (c == C_STAR) begin
                    n_phase = PH_STAR;
                end else if (c == C_SLASH) begin
                    n_phase = PH_PATH;
                    pt      = PT_PATH;
                    want    = 1'b1;
                end else begin
                    pt = PT_SCHEME;
                    if (!f_alpha(c)) begin
                        st      = ST_SCHEME;
                        n_phase = PH_FINAL;
                    end else begin
                        n_phase = PH_SCHEME;
                        n_match = match_step;
                        want    = 1'b1;
                    end
                end
            end
            PH_STAR: begin
                n_phase = PH_FINAL;
                if (f_space(c)) begin
                    n_type = TY_ASTERISK;
                    st     = ST_DONE;
                end else begin
                    st = ST_BAD_STAR;
                end
            end
            PH_SCHEME: begin
                pt = PT_SCHEME;
                if (f_alnum(c) || c == C_PLUS || c == C_MINUS || c == C_DOT) begin
                    n_match = match_step;
                    want    = 1'b1;
                end else if (c == C_COLON) begin
                    if (match == 3'd4 || match == 3'd5) begin
                        n_type  = (match == 3'd4) ? TY_HTTP : TY_HTTPS;
                        pend    = 1'b1;
                        n_len   = 16'd0;
                        n_phase = PH_SLASH;
                    end else begin
                        n_type  = TY_OTHER;
                        n_phase = PH_OTHER;
                        pt      = PT_OTHER;
                        want    = 1'b1;
                    end
                end else begin
                    st      = ST_SCHEME;
                    n_phase = PH_FINAL;
                end
            end
            PH_SLASH, PH_HOST: begin
                if (!(ph == PH_SLASH && c == C_SLASH)) begin
                    pt      = PT_HOST;
                    n_phase = PH_HOST;
                    if (ph == PH_SLASH) begin
                        n_len = 16'd0;
                    end
                    host_first = (ph == PH_SLASH) || (len == 16'd0);
                    if (host_first) begin
                        if (f_alnum(c)) begin
                            want = 1'b1;
                        end else begin
                            st      = ST_HOST;
                            n_phase = PH_FINAL;
                        end
                    end else if (f_alnum(c) || c == C_MINUS || c == C_DOT) begin
                        want = 1'b1;
                    end else if (c == C_COLON) begin
                        pend    = 1'b1;
                        n_len   = 16'd0;
                        n_phase = PH_PORT;
                    end else if (f_space(c)) begin
                        pend      = 1'b1;
                        n_implied = 1'b1;
                        st        = ST_DONE;
                        n_phase   = PH_FINAL;
                    end else if (c == C_SLASH) begin
                        pend    = 1'b1;
                        n_len   = 16'd0;
                        n_phase = PH_PATH;
                        pt      = PT_PATH;
                        want    = 1'b1;
                    end else if (c == C_QUEST) begin
                        pend      = 1'b1;
                        n_len     = 16'd0;
                        n_phase   = PH_QUERY;
                        n_implied = 1'b1;
                    end else if (c == C_HASH) begin
                        pend      = 1'b1;
                        n_len     = 16'd0;
                        n_phase   = PH_FRAG;
                        n_implied = 1'b1;
                    end else begin
                        st      = ST_HOST;
                        n_phase = PH_FINAL;
                    end
                end
            end
            PH_PORT: begin
                if (f_digit(c)) begin
                    if (port_sum >= PORT_CEILING) begin
                        st      = ST_PORT;
                        n_phase = PH_FINAL;
                    end else begin
                        n_port      = port_sum[15:0];
                        n_port_seen = 1'b1;
                    end
                end else if (!(f_space(c) || c == C_SLASH || c == C_QUEST || c == C_HASH)
                             || !n_port_seen) begin
                    st      = ST_PORT;
                    n_phase = PH_FINAL;
                end else if (f_space(c)) begin
                    n_implied = 1'b1;
                    st        = ST_DONE;
                    n_phase   = PH_FINAL;
                end else if (c == C_SLASH) begin
                    n_len   = 16'd0;
                    n_phase = PH_PATH;
                    pt      = PT_PATH;
                    want    = 1'b1;
                end else if (c == C_QUEST) begin
                    n_len     = 16'd0;
                    n_phase   = PH_QUERY;
                    n_implied = 1'b1;
                end else begin
                    n_len     = 16'd0;
                    n_phase   = PH_FRAG;
                    n_implied = 1'b1;
                end
            end
            PH_PATH: begin
                pt = PT_PATH;
                if (f_pchar(c) || c == C_SLASH || c == C_SEMI) begin
                    want = 1'b1;
                end else if (c == C_QUEST) begin
                    pend    = 1'b1;
                    n_len   = 16'd0;
                    n_phase = PH_QUERY;
                end else if (c == C_HASH) begin
                    pend    = 1'b1;
                    n_len   = 16'd0;
                    n_phase = PH_FRAG;
                end else if (f_space(c)) begin
                    pend    = 1'b1;
                    st      = ST_DONE;
                    n_phase = PH_FINAL;
                end else begin
                    st      = ST_PATH;
                    n_phase = PH_FINAL;
                end
            end
            PH_QUERY: begin
                pt = PT_QUERY;
                if (f_uric(c)) begin
                    want = 1'b1;
                end else if (c == C_HASH) begin
                    pend    = 1'b1;
                    n_len   = 16'd0;
                    n_phase = PH_FRAG;
                end else if (f_space(c)) begin
                    pend    = 1'b1;
                    st      = ST_DONE;
                    n_phase = PH_FINAL;
                end else begin
                    st      = ST_QUERY;
                    n_phase = PH_FINAL;
                end
            end
            PH_FRAG: begin
                pt = PT_FRAG;
                if (f_uric(c)) begin
                    want = 1'b1;
                end else if (f_space(c)) begin
                    pend    = 1'b1;
                    st      = ST_DONE;
                    n_phase = PH_FINAL;
                end else begin
                    st      = ST_FRAG;
                    n_phase = PH_FINAL;
                end
            end
            PH_OTHER: begin
                pt = PT_OTHER;
                if (f_space(c)) begin
                    pend    = 1'b1;
                    st      = ST_DONE;
                    n_phase = PH_FINAL;
                end else begin
                    want = 1'b1;
                end
            end
            default: begin
                st = ST_INVALID;
            end
        endcase

        kept = 1'b0;
        if (want) begin
            if (n_len >= i_part_limit) begin
                st      = ST_OVERFLOW;
                n_phase = PH_FINAL;
            end else begin
                n_len = n_len + 16'd1;
                kept  = 1'b1;
            end
        end

        o_result.status       = st;
        o_result.part         = pt;
        o_result.byte_out     = kept ? c : 8'd0;
        o_result.byte_kept    = kept;
        o_result.part_end     = pend;
        o_result.uri_type     = n_type;
        o_result.port_value   = n_port;
        o_result.port_present = n_port_seen;
        o_result.default_path = n_implied;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len       <= 16'd0;
            r_match     <= 3'd0;
            r_port      <= 16'd0;
            r_port_seen <= 1'b0;
            r_type      <= TY_UNKNOWN;
            r_implied   <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_match     <= n_match;
            r_port      <= n_port;
            r_port_seen <= n_port_seen;
            r_type      <= n_type;
            r_implied   <= n_implied;
        end
    end

endmodule

/* hdl/hurip_out_stage.sv */
`timescale 1ns / 1ps
// Result register: holds one finished transaction until the sink takes it.
// Depends on hurip_pkg.

module hurip_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hurip_pkg::t_result i_result,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output hurip_pkg::t_result o_result
);
    import hurip_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* bench/http_request_uri_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for http_request_uri_parser: directed and random request URIs.
// Depends on hurip_pkg and the http_request_uri_parser RTL; holds its own URI predictor.

module http_request_uri_parser_test;
    import hurip_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 188;

    localparam string ALPHA_SET  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string DIGIT_SET  = "0123456789";
    localparam string ALNUM_SET  = {ALPHA_SET, DIGIT_SET};
    localparam string HOST_SET   = {ALNUM_SET, "-."};
    localparam string SCHEME_SET = {ALNUM_SET, "+-.="};
    localparam string PATH_SET   = "abzAZ09-_.!~*'()%:@&=+$,/;";
    localparam string URIC_SET   = {PATH_SET, "?"};

    class uri_scoreboard;
        t_phase      phase;
        logic [15:0] part_len;
        logic [2:0]  scheme_pos;
        int          port_acc;
        bit          port_seen;
        logic [2:0]  type_seen;
        bit          path_implied;
        logic [15:0] limit;
        t_result     res;
        t_result     expected_q[$];
        int          errors;
        int          results_seen;

        function new();
            limit = PART_LIMIT_RESET;
            errors = 0;
            results_seen = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_IDLE;
            part_len = '0;
            scheme_pos = '0;
            port_acc = 0;
            port_seen = 0;
            type_seen = TY_UNKNOWN;
            path_implied = 0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alnum(logic [7:0] c);
            return is_alpha(c) || is_digit(c);
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == " " || c == "\t";
        endfunction

        function bit is_pchar(logic [7:0] c);
            return is_alnum(c) || c inside {"-", "_", ".", "!", "~", "*", "'", "(", ")",
                                            "%", ":", "@", "&", "=", "+", "$", ","};
        endfunction

        function bit is_uric(logic [7:0] c);
            return is_pchar(c) || c inside {";", "/", "?"};
        endfunction

        function void abort(logic [3:0] code);
            res.status = code;
            res.byte_kept = 0;
            phase = PH_FINAL;
        endfunction

        function void complete();
            res.status = ST_DONE;
            phase = PH_FINAL;
        endfunction

        function void keep_byte();
            if (part_len >= limit) begin
                abort(ST_OVERFLOW);
            end else begin
                part_len = part_len + 16'd1;
                res.byte_kept = 1;
            end
        endfunction

        function void open_part(t_phase next, bit implied);
            res.part_end = 1;
            part_len = '0;
            phase = next;
            if (implied) path_implied = 1;
        endfunction

        function void track_scheme(logic [7:0] c);
            string  https_txt;
            logic [7:0] low;
            https_txt = "https";
            low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            if (int'(scheme_pos) == int'(part_len) && scheme_pos < 3'd5 &&
                low == https_txt[scheme_pos])
                scheme_pos = scheme_pos + 3'd1;
            else
                scheme_pos = 3'd7;
        endfunction

        function void host_step(logic [7:0] c);
            res.part = PT_HOST;
            if (part_len == 0) begin
                if (is_alnum(c)) keep_byte();
                else abort(ST_HOST);
            end else if (is_alnum(c) || c == "-" || c == ".") begin
                keep_byte();
            end else if (c == ":") begin
                open_part(PH_PORT, 0);
            end else if (is_blank(c)) begin
                res.part_end = 1;
                path_implied = 1;
                complete();
            end else if (c == "/") begin
                open_part(PH_PATH, 0);
                res.part = PT_PATH;
                keep_byte();
            end else if (c == "?") begin
                open_part(PH_QUERY, 1);
            end else if (c == "#") begin
                open_part(PH_FRAG, 1);
            end else begin
                abort(ST_HOST);
            end
        endfunction

        function void port_step(logic [7:0] c);
            int n;
            if (is_digit(c)) begin
                n = port_acc * 10 + (int'(c) - 48);
                if (n >= 65536) begin
                    abort(ST_PORT);
                end else begin
                    port_acc = n;
                    port_seen = 1;
                end
            end else if (!(is_blank(c) || c inside {"/", "?", "#"}) || !port_seen) begin
                abort(ST_PORT);
            end else if (is_blank(c)) begin
                path_implied = 1;
                complete();
            end else if (c == "/") begin
                part_len = '0;
                phase = PH_PATH;
                res.part = PT_PATH;
                keep_byte();
            end else begin
                part_len = '0;
                phase = (c == "?") ? PH_QUERY : PH_FRAG;
                path_implied = 1;
            end
        endfunction

        function t_result advance(logic [7:0] c, logic rs);
            if (rs) clear();
            res = '0;
            case (phase)
                PH_IDLE: begin
                    if (is_blank(c)) begin
                    end else if (c == "*") begin
                        phase = PH_STAR;
                    end else if (c == "/") begin
                        phase = PH_PATH;
                        res.part = PT_PATH;
                        keep_byte();
                    end else begin
                        res.part = PT_SCHEME;
                        if (!is_alpha(c)) begin
                            abort(ST_SCHEME);
                        end else begin
                            phase = PH_SCHEME;
                            track_scheme(c);
                            keep_byte();
                        end
                    end
                end
                PH_STAR: begin
                    if (is_blank(c)) begin
                        type_seen = TY_ASTERISK;
                        complete();
                    end else begin
                        abort(ST_BAD_STAR);
                    end
                end
                PH_SCHEME: begin
                    res.part = PT_SCHEME;
                    if (is_alnum(c) || c inside {"+", "-", "."}) begin
                        track_scheme(c);
                        keep_byte();
                    end else if (c == ":") begin
                        if (scheme_pos == 3'd4 || scheme_pos == 3'd5) begin
                            type_seen = (scheme_pos == 3'd4) ? TY_HTTP : TY_HTTPS;
                            open_part(PH_SLASH, 0);
                        end else begin
                            type_seen = TY_OTHER;
                            phase = PH_OTHER;
                            res.part = PT_OTHER;
                            keep_byte();
                        end
                    end else begin
                        abort(ST_SCHEME);
                    end
                end
                PH_SLASH: begin
                    if (c != "/") begin
                        phase = PH_HOST;
                        part_len = '0;
                        host_step(c);
                    end
                end
                PH_HOST: host_step(c);
                PH_PORT: port_step(c);
                PH_PATH: begin
                    res.part = PT_PATH;
                    if (is_pchar(c) || c == "/" || c == ";") keep_byte();
                    else if (c == "?") open_part(PH_QUERY, 0);
                    else if (c == "#") open_part(PH_FRAG, 0);
                    else if (is_blank(c)) begin
                        res.part_end = 1;
                        complete();
                    end else abort(ST_PATH);
                end
                PH_QUERY: begin
                    res.part = PT_QUERY;
                    if (is_uric(c)) keep_byte();
                    else if (c == "#") open_part(PH_FRAG, 0);
                    else if (is_blank(c)) begin
                        res.part_end = 1;
                        complete();
                    end else abort(ST_QUERY);
                end
                PH_FRAG: begin
                    res.part = PT_FRAG;
                    if (is_uric(c)) keep_byte();
                    else if (is_blank(c)) begin
                        res.part_end = 1;
                        complete();
                    end else abort(ST_FRAG);
                end
                PH_OTHER: begin
                    res.part = PT_OTHER;
                    if (is_blank(c)) begin
                        res.part_end = 1;
                        complete();
                    end else keep_byte();
                end
                default: res.status = ST_INVALID;
            endcase
            res.byte_out = res.byte_kept ? c : 8'd0;
            res.uri_type = type_seen;
            res.port_value = port_acc[15:0];
            res.port_present = port_seen;
            res.default_path = path_implied;
            return res;
        endfunction

        function void note_byte(logic [7:0] c, logic rs);
            expected_q.push_back(advance(c, rs));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void cmp_field(string name, int want, int seen);
            if (want != seen) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: %0s expected %0h got %0h",
                             results_seen, name, want, seen);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result %0d arrived with none pending", results_seen);
            end else begin
                want = expected_q.pop_front();
                cmp_field("status", want.status, got.status);
                cmp_field("part", want.part, got.part);
                cmp_field("byte_out", want.byte_out, got.byte_out);
                cmp_field("byte_kept", want.byte_kept, got.byte_kept);
                cmp_field("part_end", want.part_end, got.part_end);
                cmp_field("uri_type", want.uri_type, got.uri_type);
                cmp_field("port_value", want.port_value, got.port_value);
                cmp_field("port_present", want.port_present, got.port_present);
                cmp_field("default_path", want.default_path, got.default_path);
            end
            results_seen++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    logic [7:0]  in_byte;
    logic        in_restart;
    logic        o_out_valid;
    logic        out_ready;
    logic [3:0]  o_status;
    logic [2:0]  o_part;
    logic [7:0]  o_byte_out;
    logic        o_byte_kept;
    logic        o_part_end;
    logic [2:0]  o_uri_type;
    logic [15:0] o_port_value;
    logic        o_port_present;
    logic        o_default_path;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    uri_scoreboard sb;
    int  cycles;
    int  sent;
    bit  idle_on;
    bit  hold_req;
    bit  fresh;
    int  stall_left;

    http_request_uri_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (in_byte),
        .i_restart      (in_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_status       (o_status),
        .o_part         (o_part),
        .o_byte_out     (o_byte_out),
        .o_byte_kept    (o_byte_kept),
        .o_part_end     (o_part_end),
        .o_uri_type     (o_uri_type),
        .o_port_value   (o_port_value),
        .o_port_present (o_port_present),
        .o_default_path (o_default_path),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && out_ready) begin
            got.status = o_status;
            got.part = o_part;
            got.byte_out = o_byte_out;
            got.byte_kept = o_byte_kept;
            got.part_end = o_part_end;
            got.uri_type = o_uri_type;
            got.port_value = o_port_value;
            got.port_present = o_port_present;
            got.default_path = o_default_path;
            sb.check_result(got);
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else if (hold_req) begin
            hold_req = 0;
            out_ready = 1'b0;
            stall_left = 80;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ready = 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            out_ready = 1'b1;
        end
    end

    task automatic put_byte(logic [7:0] b, logic rs);
        if (idle_on && $urandom_range(0, 6) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        in_restart = rs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(b, rs);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic put_text(string s);
        foreach (s[i]) put_byte(s[i], i == 0);
    endtask

    // random corruption and stray restarts ride on top of well-formed text
    task automatic put_sym(logic [7:0] b);
        logic rs;
        if ($urandom_range(0, 47) == 0) b = 8'($urandom);
        rs = fresh || ($urandom_range(0, 99) == 0);
        fresh = 0;
        put_byte(b, rs);
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(0, 1) ? 8'h20 : 8'h09;
    endfunction

    function automatic logic [7:0] opaque_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == 8'h20 || b == 8'h09);
        return b;
    endfunction

    task automatic put_run(string set, int maxn);
        repeat ($urandom_range(0, maxn)) put_sym(pick(set));
    endtask

    task automatic put_tail(bit with_path);
        if (with_path) begin
            put_sym("/");
            put_run(PATH_SET, 8);
        end
        if ($urandom_range(0, 2) == 0) begin
            put_sym("?");
            put_run(URIC_SET, 8);
        end
        if ($urandom_range(0, 2) == 0) begin
            put_sym("#");
            put_run(URIC_SET, 8);
        end
        put_sym(blank());
    endtask

    task automatic put_uri();
        int    kind;
        string scheme_txt;
        fresh = 1;
        repeat ($urandom_range(0, 2)) put_sym(blank());
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            put_sym("*");
            put_sym(blank());
        end else if (kind < 30) begin
            put_tail(1);
        end else if (kind < 75) begin
            scheme_txt = $urandom_range(0, 1) ? "http" : "https";
            foreach (scheme_txt[i])
                put_sym($urandom_range(0, 1) ? scheme_txt[i] - 8'd32 : scheme_txt[i]);
            put_sym(":");
            repeat ($urandom_range(0, 3)) put_sym("/");
            put_sym(pick(ALNUM_SET));
            put_run(HOST_SET, 6);
            if ($urandom_range(0, 1)) begin
                put_sym(":");
                put_run(DIGIT_SET, 6);
            end
            put_tail($urandom_range(0, 1));
        end else if (kind < 88) begin
            put_sym(pick(ALPHA_SET));
            put_run(SCHEME_SET, 4);
            put_sym(":");
            repeat ($urandom_range(0, 8)) put_sym(opaque_byte());
            put_sym(blank());
        end else begin
            repeat ($urandom_range(1, 8)) put_sym(8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_sym(8'($urandom));
    endtask

    task automatic set_limit(logic [15:0] v);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.limit = v;
    endtask

    initial begin
        logic [15:0] limits [6];
        sb = new();
        cycles = 0;
        sent = 0;
        idle_on = 1;
        hold_req = 0;
        fresh = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        in_restart = 1'b0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        put_text(" \t* ");
        put_text("*x");
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b1);
        put_text("a=");
        put_text("g.:x ");
        put_text("hTTp:h: ");
        put_text("/?# ");

        limits = '{16'd1, 16'd65535, 16'd3, 16'd2, 16'($urandom_range(4, 9)), 16'd4096};
        for (int p = 0; p < 6; p++) begin
            int target;
            set_limit(limits[p]);
            idle_on = (p != 5);
            if (p == 1) hold_req = 1;
            target = sent + PHASE_ITEMS;
            while (sent < target) put_uri();
        end
        in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/hurip_pkg.sv
hdl/hurip_in_stage.sv
hdl/hurip_core.sv
hdl/hurip_out_stage.sv
hdl/http_request_uri_parser.sv
bench/http_request_uri_parser_test.sv
